>>> rtl/trwl_pkg.sv
// trwl_pkg: widths, command and status codes for the reader-writer ticket lock
// used by the channel interfaces and by ticket_reader_writer_lock_unit
package trwl_pkg;

   localparam int TICKET_BITS = 8;
   localparam int COUNT_BITS  = 16;
   localparam int CMP_BITS    = (TICKET_BITS > COUNT_BITS) ? TICKET_BITS : COUNT_BITS;

   localparam int CMD_W       = 3;
   localparam int HELD_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int TICKET_W    = 8;
   localparam int READERS_W   = 16;

   typedef logic [TICKET_BITS-1:0] ticket_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   localparam count_type COUNT_MAX = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_TRY_READ      = 3'd0,
      CMD_READ_ACQUIRE  = 3'd1,
      CMD_READ_RELEASE  = 3'd2,
      CMD_TRY_WRITE     = 3'd3,
      CMD_WRITE_ACQUIRE = 3'd4,
      CMD_WRITE_RELEASE = 3'd5,
      CMD_POLL_READ     = 3'd6,
      CMD_POLL_WRITE    = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 3'd0,
      ST_QUEUED  = 3'd1,
      ST_BUSY    = 3'd2,
      ST_RETRY   = 3'd3,
      ST_ERROR   = 3'd4
   } status_type;

endpackage

>>> rtl/trwl_if.sv
// trwl_req_if and trwl_rsp_if: valid/ready channels of the ticket lock
// depends on trwl_pkg
interface trwl_req_if;
   logic                        valid;
   logic                        ready;
   logic [trwl_pkg::CMD_W-1:0]  command;
   logic [trwl_pkg::HELD_W-1:0] held_ticket;

   modport source (output valid, output command, output held_ticket, input ready);
   modport sink   (input valid, input command, input held_ticket, output ready);
endinterface

interface trwl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [trwl_pkg::STATUS_W-1:0]  status;
   logic [trwl_pkg::TICKET_W-1:0]  ticket;
   logic                           wake_readers;
   logic                           wake_writers;
   logic                           lock_held;
   logic [trwl_pkg::READERS_W-1:0] readers_now;

   modport source (output valid, output status, output ticket, output wake_readers,
                   output wake_writers, output lock_held, output readers_now, input ready);
   modport sink   (input valid, input status, input ticket, input wake_readers,
                   input wake_writers, input lock_held, input readers_now, output ready);
endinterface

>>> rtl/ticket_reader_writer_lock_unit.sv
// ticket_reader_writer_lock_unit: reader-writer ticket lock, one command per transaction
// depends on trwl_pkg and the channel interfaces in trwl_if.sv
// Each accepted command lands in an input register. Once the output register is free, its effect on
// the lock state is computed and written to the output register, which presents the response. One
// command is accepted every cycle while the result side keeps up; a stalled response holds one more
// command in the input register before req ready drops. The lock state registers are updated in the
// same cycle the result is registered, so back-to-back commands always see the state left by the
// one before.
module ticket_reader_writer_lock_unit (
   input  logic            clock,
   input  logic            reset,
   trwl_req_if.sink        req,
   trwl_rsp_if.source      rsp
);
   import trwl_pkg::*;

   // input register
   logic       in_valid_ff;
   cmd_type    in_cmd_ff;
   ticket_type in_held_ff;

   // lock state
   ticket_type serving_ff, serving_in;
   ticket_type next_free_ff, next_free_in;
   ticket_type group_ff, group_in;
   count_type  active_ff, active_in;
   count_type  queued_ff, queued_in;

   // result register
   logic       out_valid_ff;
   status_type status_ff, status_in;
   ticket_type ticket_ff, ticket_in;
   logic       wake_rd_ff, wake_rd_in;
   logic       wake_wr_ff, wake_wr_in;
   logic       held_ff, held_in;
   count_type  readers_ff;

   logic        out_free;
   logic        advance;
   logic        idle;
   ticket_type  serving_inc;
   ticket_type  next_inc;
   ticket_type  outstanding;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         in_cmd_ff  <= cmd_type'(req.command);
         in_held_ff <= TICKET_BITS'(req.held_ticket);
      end
   end

   assign idle        = (serving_ff == next_free_ff);
   assign serving_inc = serving_ff + 1'b1;
   assign next_inc    = next_free_ff + 1'b1;
   assign outstanding = next_free_ff - serving_ff;

   always_comb begin
      serving_in   = serving_ff;
      next_free_in = next_free_ff;
      group_in     = group_ff;
      active_in    = active_ff;
      queued_in    = queued_ff;
      status_in    = ST_GRANTED;
      ticket_in    = '0;
      wake_rd_in   = 1'b0;
      wake_wr_in   = 1'b0;
      unique case (in_cmd_ff)
         CMD_TRY_READ: begin
            if (!idle || active_ff == COUNT_MAX) begin
               status_in = ST_BUSY;
            end else begin
               active_in = active_ff + 1'b1;
            end
         end
         CMD_READ_ACQUIRE: begin
            if (idle) begin
               if (active_ff == COUNT_MAX) begin
                  status_in = ST_BUSY;
               end else begin
                  active_in = active_ff + 1'b1;
               end
            end else if (queued_ff == COUNT_MAX ||
                         CMP_BITS'(queued_ff) > CMP_BITS'(outstanding)) begin
               status_in = ST_RETRY;
            end else begin
               if (queued_ff == '0) begin
                  group_in  = next_free_ff;
                  ticket_in = next_free_ff;
               end else begin
                  ticket_in = group_ff;
               end
               queued_in = queued_ff + 1'b1;
               status_in = ST_QUEUED;
            end
         end
         CMD_READ_RELEASE: begin
            if (active_ff == '0) begin
               status_in = ST_ERROR;
            end else begin
               active_in  = active_ff - 1'b1;
               wake_wr_in = (active_ff == count_type'(1)) && !idle;
            end
         end
         CMD_TRY_WRITE: begin
            if (!idle || active_ff != '0 || queued_ff != '0) begin
               status_in = ST_BUSY;
            end else begin
               ticket_in    = next_free_ff;
               next_free_in = next_inc;
            end
         end
         CMD_WRITE_ACQUIRE: begin
            if (next_inc == serving_ff) begin
               status_in = ST_RETRY;
            end else begin
               ticket_in    = next_free_ff;
               next_free_in = next_inc;
               status_in    = (idle && active_ff == '0) ? ST_GRANTED : ST_QUEUED;
            end
         end
         CMD_WRITE_RELEASE: begin
            if (idle || active_ff != '0) begin
               status_in = ST_ERROR;
            end else begin
               serving_in = serving_inc;
               if (serving_inc == group_ff) begin
                  active_in = queued_ff;
                  queued_in = '0;
                  if (queued_ff != '0) begin
                     wake_rd_in = 1'b1;
                  end else begin
                     wake_wr_in = (serving_inc != next_free_ff);
                  end
               end else begin
                  wake_wr_in = (serving_inc != next_free_ff);
               end
            end
         end
         CMD_POLL_READ: begin
            if (in_held_ff != serving_ff) begin
               status_in = ST_BUSY;
            end
         end
         CMD_POLL_WRITE: begin
            if (in_held_ff != serving_ff || active_ff != '0) begin
               status_in = ST_BUSY;
            end
         end
         default: begin
            status_in = ST_ERROR;
         end
      endcase
      held_in = (serving_in != next_free_in) || (active_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         serving_ff   <= '0;
         next_free_ff <= '0;
         group_ff     <= '0;
         active_ff    <= '0;
         queued_ff    <= '0;
      end else begin
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            serving_ff   <= serving_in;
            next_free_ff <= next_free_in;
            group_ff     <= group_in;
            active_ff    <= active_in;
            queued_ff    <= queued_in;
         end
      end
      if (advance) begin
         status_ff  <= status_in;
         ticket_ff  <= ticket_in;
         wake_rd_ff <= wake_rd_in;
         wake_wr_ff <= wake_wr_in;
         held_ff    <= held_in;
         readers_ff <= active_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = STATUS_W'(status_ff);
   assign rsp.ticket       = TICKET_W'(ticket_ff);
   assign rsp.wake_readers = wake_rd_ff;
   assign rsp.wake_writers = wake_wr_ff;
   assign rsp.lock_held    = held_ff;
   assign rsp.readers_now  = READERS_W'(readers_ff);

endmodule
